// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the base64 stream decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character map shared by the decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_FOURTH = 2'd3;

	// Decoded bytes of one character: up to three, first byte in bits 23..16.
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  cnt;
		logic        last;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_xfer_t;

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd0;
			if (c >= 8'h41 && c <= 8'h5A) begin
				v = c - 8'h41;
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				v = c - 8'h61 + 8'd26;
			end else if (c >= 8'h30 && c <= 8'h39) begin
				v = c - 8'h30 + 8'd52;
			end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
				v = 8'd62;
			end else if (c == 8'h2F || c == 8'h5F || c == 8'h2C) begin
				v = 8'd63;
			end
			return v[5:0];
		end
	endfunction

endpackage

// File: rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, maps them to sextets and assembles groups of four;
// pushes the decoded bytes of a character as one job into the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_front import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // char_in[7:0]
	input  logic        s_axis_tlast,   // char_last
	input  logic        q_ready,
	output job_xfer_t   push
);

	logic [17:0] group_q;
	logic [1:0]  pos_q;
	logic        pad3_q;

	logic [17:0] group_d;
	logic [1:0]  pos_d;
	logic        pad3_d;
	logic [23:0] bits;
	logic [1:0]  cnt;
	logic [5:0]  sx;
	logic        is_pad;
	logic        fire;

	assign s_axis_tready = q_ready;
	assign fire          = s_axis_tvalid && q_ready;
	assign sx            = sextet_of(s_axis_tdata);
	assign is_pad        = (s_axis_tdata == PAD_CHAR);

	always_comb begin
		group_d = group_q;
		pos_d   = pos_q;
		pad3_d  = pad3_q;
		bits    = {group_q, 6'd0};
		cnt     = 2'd0;
		case (pos_q)
			POS_FIRST: begin
				group_d = {sx, 12'd0};
				pos_d   = POS_SECOND;
			end
			POS_SECOND: begin
				group_d = {group_q[17:12], sx, 6'd0};
				pos_d   = POS_THIRD;
				bits    = {group_q[17:12], sx, 12'd0};
				cnt     = s_axis_tlast ? 2'd1 : 2'd0;
			end
			POS_THIRD: begin
				group_d = {group_q[17:6], sx};
				pos_d   = POS_FOURTH;
				pad3_d  = is_pad;
				bits    = {group_q[17:6], sx, 6'd0};
				cnt     = s_axis_tlast ? 2'd2 : 2'd0;
			end
			POS_FOURTH: begin
				group_d = 18'd0;
				pos_d   = POS_FIRST;
				pad3_d  = 1'b0;
				bits    = {group_q, sx};
				if (s_axis_tlast && is_pad) begin
					cnt = pad3_q ? 2'd1 : 2'd2;
				end else begin
					cnt = 2'd3;
				end
			end
			default: begin
				group_d = 18'd0;
				pos_d   = POS_FIRST;
			end
		endcase
		if (s_axis_tlast) begin
			group_d = 18'd0;
			pos_d   = POS_FIRST;
			pad3_d  = 1'b0;
		end
	end

	always_comb begin
		push.valid    = fire && (cnt != 2'd0);
		push.job.bits = bits;
		push.job.cnt  = cnt;
		push.job.last = s_axis_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= 18'd0;
			pos_q   <= POS_FIRST;
			pad3_q  <= 1'b0;
		end else if (fire) begin
			group_q <= group_d;
			pos_q   <= pos_d;
			pad3_q  <= pad3_d;
		end
	end

	`ASSERT_NEXT(a_last_restarts_group, clk, arst_n, fire && s_axis_tlast, pos_q == POS_FIRST && group_q == 18'd0 && !pad3_q, "group not cleared after last character")

endmodule

// File: rtl/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Short job queue between the character front end and the byte back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_fifo import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_xfer_t push,
	output logic      ready,
	output job_xfer_t head,
	input  logic      pop
);

	job_t mem [FIFO_DEPTH];

	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign ready      = (count_q != FIFO_CW'(FIFO_DEPTH));
	assign do_push    = push.valid && ready;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.job   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_IMPLY(a_no_push_when_full, clk, arst_n, push.valid, ready, "job pushed into full queue")
	`ASSERT_ALWAYS(a_count_bounded, clk, arst_n, count_q <= FIFO_CW'(FIFO_DEPTH), "queue count overflow")
	`ASSERT_IMPLY(a_no_empty_job, clk, arst_n, head.valid, head.job.cnt != 2'd0, "empty job in queue")

endmodule

// File: rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Takes jobs from the queue and sends their bytes one per transfer
// through an output register.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_xfer_t  head,
	output logic       pop,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // byte_out[7:0]
	output logic       m_axis_tlast    // byte_last
);

	job_t        cur_q;
	logic        cur_valid_q;
	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic        out_last_q;

	logic        advance;
	logic        final_byte;
	logic [7:0]  sel_byte;

	assign advance    = cur_valid_q && (!out_valid_q || m_axis_tready);
	assign final_byte = (idx_q == cur_q.cnt - 2'd1);
	assign pop        = head.valid && (!cur_valid_q || (advance && final_byte));

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = cur_q.bits[23:16];
			2'd1:    sel_byte = cur_q.bits[15:8];
			default: sel_byte = cur_q.bits[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (advance) begin
				if (final_byte) begin
					cur_valid_q <= 1'b0;
					idx_q       <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.job;
		end
		if (advance) begin
			out_data_q <= sel_byte;
			out_last_q <= cur_q.last && final_byte;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Tolerant base64 decoder: one character in per transfer, decoded bytes out.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries one text character, s_axis_tlast marks
// the final character of an encoded stream. Output stream: m_axis_tdata
// carries one decoded byte, m_axis_tlast marks the final byte of the stream.
// Both +, - and . decode to 62, /, _ and , to 63; any other character,
// padding included, counts as zero. A padded last group gives one or two
// bytes; a last tail of two or three characters gives one or two bytes; a
// lone last character gives no byte and so no byte with m_axis_tlast set.
// Throughput: one character per cycle while the queue has room, one byte
// per cycle out while the receiver is ready. The first byte of a character
// passes the front end, job queue, byte sequencer and output register.
// A four-entry job queue decouples the two sides; when the receiver stalls,
// the queue fills and s_axis_tready drops once it holds four jobs.
// Reset clears the group state, empties the queue and clears the output
// valid flag; the block is ready for input as soon as reset is released.
// ----------------------------------------------------------------------------
module base64_stream_decoder import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // char_in[7:0]
	input  logic       s_axis_tlast,   // char_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // byte_out[7:0]
	output logic       m_axis_tlast    // byte_last
);

	job_xfer_t push;
	job_xfer_t head;
	logic      q_ready;
	logic      pop;

	b64d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_ready       (q_ready),
		.push          (push)
	);

	b64d_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ready  (q_ready),
		.head   (head),
		.pop    (pop)
	);

	b64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
